/* rtl/bpsm_pkg.sv */
// ----------------------------------------------------------------------------
// bpsm_pkg
// Shared types, constants and helpers for the byte pattern stream matcher.
// ----------------------------------------------------------------------------
package bpsm_pkg;

  localparam int unsigned MaxPatternDef = 16;
  localparam int unsigned OffsetBitsDef = 32;

  localparam int unsigned CfgW      = 64;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned PatStored = 16;   // pattern bytes held in the two registers
  localparam int unsigned MatchW    = 32;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  localparam logic [7:0] UpperA  = 8'd65;
  localparam logic [7:0] UpperZ  = 8'd90;
  localparam logic [7:0] CaseGap = 8'd32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatLow     = 3'd0,
    CfgPatHigh    = 3'd1,
    CfgPatLength  = 3'd2,
    CfgTextMode   = 3'd3,
    CfgCaseSens   = 3'd4,
    CfgWideChars  = 3'd5,
    CfgLittleEnd  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [MatchW-1:0] match_offset;
    logic              wide_form;
    logic              last_of_run;
  } out_t;

  typedef struct packed {
    logic [MatchW-1:0] offset;
    logic              wide;
  } hit_t;

  // all results of one input word
  typedef struct packed {
    hit_t first;
    logic two;
    hit_t second;
  } grp_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic cs);
    if (!cs && b >= UpperA && b <= UpperZ) begin
      return b + CaseGap;
    end
    return b;
  endfunction

endpackage

/* rtl/bpsm_front.sv */
// ----------------------------------------------------------------------------
// bpsm_front
// Holds the configuration, the byte window and stream position; compares the
// window against the pattern each accepted word and emits a result group.
// ----------------------------------------------------------------------------
module bpsm_front #(
  parameter int unsigned MaxPattern = bpsm_pkg::MaxPatternDef,
  parameter int unsigned OffsetBits = bpsm_pkg::OffsetBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bpsm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bpsm_pkg::CfgW-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  input  bpsm_pkg::in_t                    in_i,
  output logic                             grp_valid_o,
  output bpsm_pkg::grp_t                   grp_o
);
  import bpsm_pkg::*;

  localparam int unsigned WinDepth = 2 * MaxPattern - 1;
  localparam int unsigned LenW     = $clog2(MaxPattern + 1);
  localparam int unsigned SeenW    = $clog2(WinDepth + 1);
  localparam int unsigned CmpW     = SeenW + 1;
  localparam int unsigned PatIdxW  = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int unsigned OIdxW    = LenW + 1;

  logic [CfgW-1:0]       pat_low_q, pat_high_q;
  logic [4:0]            plen_q;
  logic                  text_q, cs_q, wide_q, le_q;

  logic [7:0]            win_q [WinDepth];
  logic [7:0]            nw    [WinDepth];
  logic [OffsetBits-1:0] pos_q;
  logic [SeenW-1:0]      seen_q, seen_d;
  logic [LenW-1:0]       hold_q, hold_d;

  logic [7:0]            pat [MaxPattern];
  logic [7:0]            rp  [MaxPattern];
  logic [7:0]            bp  [MaxPattern];
  logic [MaxPattern-1:0] bin_ok, nar_ok, wid_ok;
  logic [WinDepth-1:0]   old_ok;
  logic [LenW-1:0]       len;
  logic [CmpW-1:0]       len_cmp, wlen_cmp, seen_cmp;
  logic                  bin_hit, nar_hit, wid_hit, nar_all, old_all;
  logic [OffsetBits-1:0] back_n, back_w;
  hit_t                  hit_n, hit_w;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      plen_q     <= 5'd1;
      text_q     <= 1'b0;
      cs_q       <= 1'b0;
      wide_q     <= 1'b1;
      le_q       <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPatLow:    pat_low_q  <= cfg_data_i;
        CfgPatHigh:   pat_high_q <= cfg_data_i;
        CfgPatLength: plen_q     <= cfg_data_i[4:0];
        CfgTextMode:  text_q     <= cfg_data_i[0];
        CfgCaseSens:  cs_q       <= cfg_data_i[0];
        CfgWideChars: wide_q     <= cfg_data_i[0];
        CfgLittleEnd: le_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (plen_q == 5'd0) begin
      len = LenW'(1);
    end else if (int'(plen_q) > MaxPattern) begin
      len = LenW'(MaxPattern);
    end else begin
      len = LenW'(plen_q);
    end
  end

  // window after shifting in the new byte
  assign nw[0] = in_i.data_byte;
  for (genvar i = 1; i < WinDepth; i++) begin : g_nw
    assign nw[i] = win_q[i-1];
  end

  for (genvar k = 0; k < MaxPattern; k++) begin : g_pat
    if (k < 8) begin : g_lo
      assign pat[k] = pat_low_q[8*k +: 8];
    end else if (k < PatStored) begin : g_hi
      assign pat[k] = pat_high_q[8*(k-8) +: 8];
    end else begin : g_zero
      assign pat[k] = 8'd0;
    end
  end

  // rp[j]: pattern byte that lines up with window byte j (newest = last byte)
  for (genvar j = 0; j < MaxPattern; j++) begin : g_cmp
    logic [LenW-1:0] idx;
    logic            in_len;
    assign idx    = len - LenW'(1) - LenW'(j);
    assign in_len = LenW'(j) < len;
    assign rp[j]  = (idx < LenW'(MaxPattern)) ? pat[idx[PatIdxW-1:0]] : 8'd0;
    assign bp[j]  = le_q ? pat[j] : rp[j];

    assign bin_ok[j] = !in_len || (nw[j] == bp[j]);
    assign nar_ok[j] = !in_len || (fold_byte(nw[j], cs_q) == fold_byte(rp[j], cs_q));

    if (j < MaxPattern - 1) begin : g_gap
      assign wid_ok[j] = !in_len ||
                         ((fold_byte(nw[2*j], cs_q) == fold_byte(rp[j], cs_q)) &&
                          ((LenW'(j + 1) >= len) || (nw[2*j+1] == 8'd0)));
    end else begin : g_end
      assign wid_ok[j] = !in_len || (fold_byte(nw[2*j], cs_q) == fold_byte(rp[j], cs_q));
    end
  end

  // narrow form from the wide start: window bytes 2L-2 down to L-1
  for (genvar m = 0; m < WinDepth; m++) begin : g_old
    logic [OIdxW-1:0] oidx;
    logic             in_rng;
    assign oidx      = {len, 1'b0} - OIdxW'(2) - OIdxW'(m);
    assign in_rng    = oidx < OIdxW'(len);
    assign old_ok[m] = !in_rng ||
                       (fold_byte(nw[m], cs_q) == fold_byte(pat[oidx[PatIdxW-1:0]], cs_q));
  end

  assign seen_d   = (seen_q < SeenW'(WinDepth)) ? seen_q + SeenW'(1) : seen_q;
  assign seen_cmp = CmpW'(seen_d);
  assign len_cmp  = CmpW'(len);
  assign wlen_cmp = CmpW'({len, 1'b0}) - CmpW'(1);

  assign nar_all = &nar_ok;
  assign old_all = &old_ok;
  assign bin_hit = !text_q && (hold_q == '0) && (seen_cmp >= len_cmp) && (&bin_ok);
  assign nar_hit = text_q && (seen_cmp >= len_cmp) && nar_all;
  assign wid_hit = text_q && wide_q && (len >= LenW'(2)) && (seen_cmp >= wlen_cmp) &&
                   (&wid_ok) && !old_all;

  assign back_n = OffsetBits'(len) - OffsetBits'(1);
  assign back_w = OffsetBits'({len, 1'b0}) - OffsetBits'(2);

  assign hit_n.offset = MatchW'(pos_q - back_n);
  assign hit_n.wide   = 1'b0;
  assign hit_w.offset = MatchW'(pos_q - back_w);
  assign hit_w.wide   = 1'b1;

  // wide match starts earlier, so it leads the group
  always_comb begin
    grp_o.first  = wid_hit ? hit_w : hit_n;
    grp_o.two    = wid_hit && nar_hit;
    grp_o.second = hit_n;
  end
  assign grp_valid_o = in_valid_i && (bin_hit || nar_hit || wid_hit);

  always_comb begin
    hold_d = hold_q;
    if (!text_q) begin
      if (bin_hit) begin
        hold_d = len - LenW'(1);
      end else if (hold_q != '0) begin
        hold_d = hold_q - LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinDepth; i++) begin
        win_q[i] <= 8'd0;
      end
      pos_q  <= '0;
      seen_q <= '0;
      hold_q <= '0;
    end else if (in_valid_i) begin
      if (in_i.end_of_buffer) begin
        for (int i = 0; i < WinDepth; i++) begin
          win_q[i] <= 8'd0;
        end
        pos_q  <= '0;
        seen_q <= '0;
        hold_q <= '0;
      end else begin
        for (int i = 0; i < WinDepth; i++) begin
          win_q[i] <= nw[i];
        end
        pos_q  <= pos_q + OffsetBits'(1);
        seen_q <= seen_d;
        hold_q <= hold_d;
      end
    end
  end

endmodule

/* rtl/bpsm_queue.sv */
// ----------------------------------------------------------------------------
// bpsm_queue
// Short queue of result groups between the compare front and the output side.
// ----------------------------------------------------------------------------
module bpsm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  bpsm_pkg::grp_t wr_grp_i,
  input  logic           rd_i,
  output bpsm_pkg::grp_t rd_grp_o,
  output logic           full_o,
  output logic           empty_o
);
  import bpsm_pkg::*;

  grp_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o   = (cnt_q == QCntW'(QDepth));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_grp_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/bpsm_back.sv */
// ----------------------------------------------------------------------------
// bpsm_back
// Splits each queued result group into single results, one per pop.
// ----------------------------------------------------------------------------
module bpsm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           grp_valid_i,
  input  bpsm_pkg::grp_t grp_i,
  output logic           grp_done_o,
  input  logic           pop,
  output logic           empty,
  output bpsm_pkg::out_t out_o
);
  import bpsm_pkg::*;

  logic sub_q;   // set while the second result of the head group is shown
  logic take;

  assign empty = !grp_valid_i;
  assign take  = pop && grp_valid_i;

  assign out_o.match_offset = sub_q ? grp_i.second.offset : grp_i.first.offset;
  assign out_o.wide_form    = sub_q ? grp_i.second.wide   : grp_i.first.wide;
  assign out_o.last_of_run  = sub_q || !grp_i.two;

  assign grp_done_o = take && (sub_q || !grp_i.two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else if (take) begin
      sub_q <= !sub_q && grp_i.two;
    end
  end

endmodule

/* rtl/byte_pattern_stream_matcher.sv */
// ----------------------------------------------------------------------------
// byte_pattern_stream_matcher
// Streams a buffer one byte per word and reports the start offset of each
// pattern match, in binary (exact, non-overlapping) or text (optionally folded and wide) mode.
// ----------------------------------------------------------------------------
// One byte is accepted per clock while full is low. Its compare against the
// whole window is done in the cycle it is accepted; its results (zero, one or
// two) are registered as one group in the queue ahead of the output. Each result
// takes one pop, so a byte with two results needs two pops; a four-entry queue
// of groups between compare and output absorbs that, and full rises only when
// those four groups are all waiting. No clearing pass is needed after reset.
module byte_pattern_stream_matcher #(
  parameter int unsigned MaxPattern = bpsm_pkg::MaxPatternDef,
  parameter int unsigned OffsetBits = bpsm_pkg::OffsetBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bpsm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bpsm_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  bpsm_pkg::in_t                in_i,
  output logic                         empty,
  input  logic                         pop,
  output bpsm_pkg::out_t               out_o
);
  import bpsm_pkg::*;

  logic accept;
  logic grp_valid, grp_done, q_empty;
  grp_t grp_wr, grp_rd;

  assign accept = push && !full;

  bpsm_front #(
    .MaxPattern (MaxPattern),
    .OffsetBits (OffsetBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (accept),
    .in_i        (in_i),
    .grp_valid_o (grp_valid),
    .grp_o       (grp_wr)
  );

  bpsm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (grp_valid),
    .wr_grp_i (grp_wr),
    .rd_i     (grp_done),
    .rd_grp_o (grp_rd),
    .full_o   (full),
    .empty_o  (q_empty)
  );

  bpsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (!q_empty),
    .grp_i       (grp_rd),
    .grp_done_o  (grp_done),
    .pop         (pop),
    .empty       (empty),
    .out_o       (out_o)
  );

endmodule

/* rtl/bpsm_checker.sv */
// ----------------------------------------------------------------------------
// bpsm_checker
// Port-level checks for the byte pattern stream matcher, bound to the top.
// ----------------------------------------------------------------------------
module bpsm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input bpsm_pkg::out_t               out_o
);
  import bpsm_pkg::*;

  // a waiting word holds until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(out_o))
    else $error("result changed while waiting");

  // only the wide result of a pair can be followed by another
  a_first_is_wide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_o.last_of_run) |-> out_o.wide_form)
    else $error("non-final result is not wide");

  // the partner of a pair is ready right after the first is taken
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !out_o.last_of_run) |=> (!empty && out_o.last_of_run && !out_o.wide_form))
    else $error("second result of a pair missing");

  // nothing shows up without an accepted byte
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !(push && !full)) |=> empty)
    else $error("result without input");

endmodule

bind byte_pattern_stream_matcher bpsm_checker u_checker (.*);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for byte_pattern_stream_matcher. Byte words go in
// through push/full, and a scoreboard predicts every match from its own copy
// of the registers and window. Each popped result is checked in order.
// Directed runs come first, then random runs over binary and text settings,
// most with random idling on both sides, and one long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bpsm_pkg::*;

  localparam int unsigned WinDepth = 2 * MaxPatternDef - 1;
  localparam int unsigned LongHold = 60;

  class match_ledger;
    logic [CfgW-1:0]   pat_lo;
    logic [CfgW-1:0]   pat_hi;
    logic [4:0]        len_reg;
    logic              text_on;
    logic              case_exact;
    logic              wide_on;
    logic              little_end;
    logic [7:0]        window [WinDepth];
    logic [MatchW-1:0] position;
    int unsigned       seen;
    int unsigned       holdoff;
    out_t              step_hits [$];
    out_t              awaited [$];
    int unsigned       errors;
    int unsigned       words;
    int unsigned       matched;
    int unsigned       wide_seen;

    function new();
      pat_lo     = '0;
      pat_hi     = '0;
      len_reg    = 5'd1;
      text_on    = 1'b0;
      case_exact = 1'b0;
      wide_on    = 1'b1;
      little_end = 1'b1;
      errors     = 0;
      words      = 0;
      matched    = 0;
      wide_seen  = 0;
      clear_buffer();
    endfunction

    function void clear_buffer();
      foreach (window[i]) window[i] = 8'h00;
      position = '0;
      seen     = 0;
      holdoff  = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] v);
      case (idx)
        CfgPatLow:    pat_lo = v;
        CfgPatHigh:   pat_hi = v;
        CfgPatLength: len_reg = v[4:0];
        CfgTextMode:  text_on = v[0];
        CfgCaseSens:  case_exact = v[0];
        CfgWideChars: wide_on = v[0];
        CfgLittleEnd: little_end = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_len();
      if (len_reg == 5'd0) return 1;
      if (len_reg > MaxPatternDef) return MaxPatternDef;
      return len_reg;
    endfunction

    function logic [7:0] pat_byte(int unsigned k);
      if (k < 8) return pat_lo[8*k +: 8];
      if (k < 16) return pat_hi[8*(k-8) +: 8];
      return 8'h00;
    endfunction

    function logic [7:0] lower(logic [7:0] b);
      if (!case_exact && b >= UpperA && b <= UpperZ) return b + CaseGap;
      return b;
    endfunction

    // d is the distance from the newest byte back to the start byte
    function bit narrow_at(int unsigned d, int unsigned len);
      for (int unsigned k = 0; k < len; k++) begin
        if (lower(window[d-k]) != lower(pat_byte(k))) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit wide_at(int unsigned d, int unsigned len);
      if (lower(window[d]) != lower(pat_byte(0))) return 1'b0;
      for (int unsigned k = 1; k < len; k++) begin
        if (window[d-2*k+1] != 8'h00) return 1'b0;
        if (lower(window[d-2*k]) != lower(pat_byte(k))) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void add_hit(int unsigned back, logic wide);
      out_t h;
      h.match_offset = position - MatchW'(back);
      h.wide_form    = wide;
      h.last_of_run  = 1'b0;
      step_hits.push_back(h);
    endfunction

    // accepted byte word: shift it in and queue the matches it completes
    function void take_byte(in_t w);
      int unsigned len;
      bit          blocked;
      bit          ok;
      len = eff_len();
      words++;
      step_hits.delete();
      for (int i = WinDepth - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = w.data_byte;
      if (seen < WinDepth) seen++;
      if (!text_on) begin
        blocked = (holdoff != 0);
        if (holdoff != 0) holdoff--;
        if (!blocked && seen >= len) begin
          ok = 1'b1;
          for (int unsigned k = 0; k < len; k++) begin
            if (window[len-1-k] != pat_byte(little_end ? len - 1 - k : k)) ok = 1'b0;
          end
          if (ok) begin
            add_hit(len - 1, 1'b0);
            holdoff = len - 1;
          end
        end
      end else begin
        if (wide_on && len >= 2 && seen >= 2*len - 1 &&
            wide_at(2*len - 2, len) && !narrow_at(2*len - 2, len)) begin
          add_hit(2*len - 2, 1'b1);
        end
        if (seen >= len && narrow_at(len - 1, len)) add_hit(len - 1, 1'b0);
      end
      if (step_hits.size() != 0) step_hits[step_hits.size()-1].last_of_run = 1'b1;
      foreach (step_hits[i]) awaited.push_back(step_hits[i]);
      position++;
      if (w.end_of_buffer) clear_buffer();
    endfunction

    function void check_match(out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: offset %0d wide %0b last %0b", $time,
                 got.match_offset, got.wide_form, got.last_of_run);
        return;
      end
      want = awaited.pop_front();
      matched++;
      if (want.wide_form) wide_seen++;
      if (got.match_offset !== want.match_offset) begin
        errors++;
        $display("%0t: match_offset expected %0d actual %0d", $time,
                 want.match_offset, got.match_offset);
      end
      if (got.wide_form !== want.wide_form) begin
        errors++;
        $display("%0t: wide_form expected %0b actual %0b", $time,
                 want.wide_form, got.wide_form);
      end
      if (got.last_of_run !== want.last_of_run) begin
        errors++;
        $display("%0t: last_of_run expected %0b actual %0b", $time,
                 want.last_of_run, got.last_of_run);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                push;
  logic                full;
  in_t                 in_i;
  logic                empty;
  logic                pop;
  out_t                out_o;

  match_ledger ledger = new();
  logic [7:0]  run_bytes [$];
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned holds_asked;
  int unsigned settings_used;

  byte_pattern_stream_matcher u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_i       (in_i),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #1ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random pops, plus a long hold-off whenever one is asked for
  initial begin : receiver
    int unsigned stall_left;
    int unsigned holds_done;
    stall_left = 0;
    holds_done = 0;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) ledger.check_match(out_o);
      if (stall_left == 0 && holds_done < holds_asked) begin
        stall_left = LongHold;
        holds_done++;
      end
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic push_word(input logic [7:0] b, input logic close);
    in_t w;
    w.data_byte     = b;
    w.end_of_buffer = close;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= w;
    do @(posedge clk_i); while (full);
    ledger.take_byte(w);
  endtask

  task automatic send_run(input logic close);
    foreach (run_bytes[i]) push_word(run_bytes[i], close && i == run_bytes.size() - 1);
  endtask

  // wait for every expected word, then for anything still in flight
  task automatic settle();
    push <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    ledger.set_reg(idx, v);
  endtask

  // unused upper bits carry random junk
  task automatic program_regs(input logic txt, input logic cs, input logic wd,
                              input logic le, input logic [4:0] len,
                              input logic [CfgW-1:0] lo, input logic [CfgW-1:0] hi);
    write_reg(CfgPatLow, lo);
    write_reg(CfgPatHigh, hi);
    write_reg(CfgPatLength, CfgW'({$urandom, $urandom_range(7), len}));
    write_reg(CfgTextMode, CfgW'({$urandom, $urandom_range(32'h7fff_ffff), txt}));
    write_reg(CfgCaseSens, CfgW'({$urandom, $urandom_range(32'h7fff_ffff), cs}));
    write_reg(CfgWideChars, CfgW'({$urandom, $urandom_range(32'h7fff_ffff), wd}));
    write_reg(CfgLittleEnd, CfgW'({$urandom, $urandom_range(32'h7fff_ffff), le}));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [CfgW-1:0] text_pattern();
    logic [CfgW-1:0] p;
    int unsigned     r;
    for (int k = 0; k < 8; k++) begin
      r = $urandom_range(9);
      if (r < 4) p[8*k +: 8] = UpperA + 8'($urandom_range(25));
      else if (r < 8) p[8*k +: 8] = UpperA + CaseGap + 8'($urandom_range(25));
      else if (r == 8) p[8*k +: 8] = 8'h00;
      else p[8*k +: 8] = 8'($urandom);
    end
    return p;
  endfunction

  // mostly planted patterns (some corrupted or in the wrong order), rest noise
  task automatic random_run(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    int unsigned idx;
    logic [7:0]  b;
    logic        flip;
    logic        wide_form;
    sent = 0;
    while (sent < count) begin
      run_bytes.delete();
      len = ledger.eff_len();
      if ($urandom_range(99) < 60) begin
        flip      = ($urandom_range(9) == 0);
        wide_form = ledger.text_on && ($urandom_range(1) == 1);
        for (int unsigned k = 0; k < len; k++) begin
          idx = (!ledger.text_on && (ledger.little_end ^ flip)) ? len - 1 - k : k;
          b   = ledger.pat_byte(idx);
          if (ledger.text_on && $urandom_range(3) == 0 &&
              ((b >= UpperA && b <= UpperZ) ||
               (b >= UpperA + CaseGap && b <= UpperZ + CaseGap))) begin
            b = b ^ CaseGap;
          end
          if (wide_form && k != 0) run_bytes.push_back(8'h00);
          run_bytes.push_back(b);
        end
        if ($urandom_range(99) < 15) begin
          run_bytes[$urandom_range(run_bytes.size() - 1)] = 8'($urandom);
        end
      end else begin
        repeat ($urandom_range(6, 1)) begin
          case ($urandom_range(3))
            0: b = 8'($urandom);
            1: b = 8'h00;
            2: b = ledger.pat_byte($urandom_range(len - 1));
            default: b = 8'($urandom_range(122, 65));
          endcase
          run_bytes.push_back(b);
        end
      end
      foreach (run_bytes[i]) push_word(run_bytes[i], $urandom_range(99) < 2);
      sent += run_bytes.size();
    end
  endtask

  initial begin : stimulus
    rst_ni     <= 1'b0;
    push       <= 1'b0;
    in_i       <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    send_idle     = 29;
    recv_idle     = 53;
    holds_asked   = 0;
    settings_used = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // settings after reset: binary, length one, zero pattern
    run_bytes = {8'h00, 8'hff, 8'h00};
    send_run(1'b0);
    settle();
    // binary overlap: a match blocks the next length-1 bytes
    program_regs(1'b0, 1'b0, 1'b0, 1'b0, 5'd2, 64'h0000_0000_0000_aaaa, '0);
    run_bytes = {8'haa, 8'haa, 8'haa, 8'haa, 8'haa};
    send_run(1'b1);
    settle();
    // binary little-endian compares the pattern reversed
    program_regs(1'b0, 1'b0, 1'b0, 1'b1, 5'd3, 64'h0000_0000_0003_0201, '0);
    run_bytes = {8'h03, 8'h02, 8'h01};
    send_run(1'b1);
    settle();
    // wide and narrow match ending on the same byte
    program_regs(1'b1, 1'b0, 1'b1, 1'b0, 5'd2, 64'h0000_0000_0000_4100, '0);
    run_bytes = {8'h00, 8'h00, 8'h61};
    send_run(1'b1);
    settle();
    // length one text, around the folding range
    program_regs(1'b1, 1'b0, 1'b1, 1'b0, 5'd1, 64'h0000_0000_0000_005a, '0);
    run_bytes = {8'h7a, 8'h5a, 8'h40, 8'h5b, 8'h00, 8'h60};
    send_run(1'b1);
    settle();
    // exact case; a start that fits both forms is reported narrow only
    program_regs(1'b1, 1'b1, 1'b1, 1'b0, 5'd3, 64'h0000_0000_0000_0061, '0);
    run_bytes = {8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h00, 8'h00};
    send_run(1'b1);
    settle();

    program_regs(1'b0, 1'b0, 1'b0, 1'b1, 5'd4, {$urandom, $urandom}, {$urandom, $urandom});
    random_run(50);
    settle();
    program_regs(1'b1, 1'b0, 1'b1, 1'b0, 5'd5, text_pattern(), text_pattern());
    random_run(50);
    settle();
    program_regs(1'b0, 1'b0, 1'b0, 1'b0, 5'd16, {$urandom, $urandom}, {$urandom, $urandom});
    random_run(50);
    settle();

    send_idle = 53;
    recv_idle = 29;
    // every byte of zero matches here, so the long hold-off fills the block
    program_regs(1'b0, 1'b1, 1'b1, 1'b1, 5'd0, '0, '0);
    holds_asked++;
    random_run(50);
    settle();
    program_regs(1'b1, 1'b1, 1'b1, 1'b0, 5'd2, text_pattern(), text_pattern());
    random_run(50);
    settle();
    program_regs(1'b1, 1'b0, 1'b0, 1'b0, 5'd31, text_pattern(), text_pattern());
    random_run(50);
    settle();

    send_idle = 0;
    recv_idle = 0;
    program_regs(1'b1, 1'b0, 1'b1, 1'b1, 5'd1, text_pattern(), text_pattern());
    random_run(50);
    settle();
    program_regs(1'b0, 1'b0, 1'b1, 1'b1, 5'd1, '1, '1);
    random_run(50);
    settle();
    program_regs(1'b1, 1'b0, 1'b1, 1'b0, 5'd16, text_pattern(), text_pattern());
    random_run(60);
    settle();

    $display("ran %0d byte words under %0d register settings", ledger.words, settings_used);
    $display("checked %0d results, %0d of them wide matches", ledger.matched,
             ledger.wide_seen);
    if (ledger.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
